/* rtl/core/snrc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snrc_pkg
// Types, constants and rank prefix tables for the sorted nibble rank codec.
// ----------------------------------------------------------------------------
package snrc_pkg;

    localparam int unsigned NIBBLES    = 4;
    localparam int unsigned VALUES     = 16;
    localparam int unsigned CODE_W     = 12;
    localparam int unsigned NIB_W      = 4;
    localparam int unsigned PFX_DEPTH  = VALUES + 1;
    localparam int unsigned PFX_IDX_W  = $clog2(PFX_DEPTH);

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [NIB_W-1:0]  nibble_t;

    localparam code_t TOTAL_CODES = 12'd3876;

    // operation field codes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef struct packed {
        logic    operation;
        nibble_t in_nibble_0;
        nibble_t in_nibble_1;
        nibble_t in_nibble_2;
        nibble_t in_nibble_3;
        code_t   code_in;
    } in_item_t;

    typedef struct packed {
        code_t   code_out;
        nibble_t out_nibble_0;
        nibble_t out_nibble_1;
        nibble_t out_nibble_2;
        nibble_t out_nibble_3;
    } out_item_t;

    // encode lane result: rank contribution and order check
    typedef struct packed {
        code_t diff;
        logic  ok;
    } enc_lane_t;

    // decode step result: chosen nibble and remaining rank
    typedef struct packed {
        nibble_t nib;
        code_t   rem;
    } dec_step_t;

    // PREFIX[len][x]: number of non-decreasing tails of length len+1 whose
    // first value is below x (values 0..15)
    typedef code_t [PFX_DEPTH-1:0] pfx_row_t;
    typedef pfx_row_t [NIBBLES-1:0] pfx_tbl_t;

    function automatic pfx_tbl_t build_prefix();
        pfx_tbl_t    t;
        int unsigned r;
        int unsigned acc;
        for (int unsigned len = 0; len < NIBBLES; len++)
        begin
            acc = 0;
            for (int unsigned x = 0; x < PFX_DEPTH; x++)
            begin
                t[len][x] = code_t'(acc);
                r = VALUES - x;
                case (len)
                    0:       acc = acc + 1;
                    1:       acc = acc + r;
                    2:       acc = acc + r * (r + 1) / 2;
                    default: acc = acc + r * (r + 1) * (r + 2) / 6;
                endcase
            end
        end
        return t;
    endfunction

    localparam pfx_tbl_t PREFIX = build_prefix();

endpackage
`default_nettype wire

/* rtl/core/sorted_nibble_rank_codec_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_nibble_rank_codec_core
// Semi-sorting codec: ranks a non-decreasing nibble quadruple, or expands a
// rank back to its quadruple.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------
//   in      | in_valid/in_ready  | in_data  (in_item_t)
//   out     | out_valid/out_ready| out_data (out_item_t)
//
// Four-stage pipeline, one transaction per cycle sustained while out_ready is high.
// Pipeline depth is set by the four dependent decode steps, one per stage; encode
// lanes run in stage 1 and their merge adder in stage 2.
// Each stage holds when the stage after it is full and stalled, so bubbles
// are squeezed out. Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module sorted_nibble_rank_codec_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  snrc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output snrc_pkg::out_item_t out_data
);
    import snrc_pkg::*;

    typedef struct packed {
        logic                 op;
        logic                 oor;
        logic                 enc_ok;
        code_t [NIBBLES-1:0]  diff;
        code_t                enc_code;
        code_t                rem;
        nibble_t [NIBBLES-1:0] nib;
    } stage_t;

    localparam int unsigned STAGES = 4;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] free;

    stage_t    s1_reg, s1_next;
    stage_t    s2_reg, s2_next;
    stage_t    s3_reg, s3_next;
    out_item_t out_reg, out_next;

    enc_lane_t [NIBBLES-1:0] lane;
    dec_step_t               d0, d1, d2, d3;

    // ------------------------------------------------------------------
    // handshake chain
    // ------------------------------------------------------------------
    always_comb
    begin
        free[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            free[i] = !vld_reg[i] || free[i+1];
        end
        vld_next[0] = free[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            vld_next[i] = free[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    assign in_ready  = free[0];
    assign out_valid = vld_reg[STAGES-1];
    assign out_data  = out_reg;

    // ------------------------------------------------------------------
    // stage 1: encode lanes, first decode step
    // ------------------------------------------------------------------
    snrc_enc_lane #(.LEN(3)) u_lane0 (
        .nib(in_data.in_nibble_0), .prev(4'd0), .res(lane[0]));
    snrc_enc_lane #(.LEN(2)) u_lane1 (
        .nib(in_data.in_nibble_1), .prev(in_data.in_nibble_0), .res(lane[1]));
    snrc_enc_lane #(.LEN(1)) u_lane2 (
        .nib(in_data.in_nibble_2), .prev(in_data.in_nibble_1), .res(lane[2]));
    snrc_enc_lane #(.LEN(0)) u_lane3 (
        .nib(in_data.in_nibble_3), .prev(in_data.in_nibble_2), .res(lane[3]));

    snrc_dec_step #(.LEN(3)) u_step0 (
        .rem(in_data.code_in), .prev(4'd0), .res(d0));

    always_comb
    begin
        s1_next          = s1_reg;
        s1_next.op       = in_data.operation;
        s1_next.oor      = (in_data.code_in >= TOTAL_CODES);
        s1_next.enc_ok   = lane[0].ok && lane[1].ok && lane[2].ok && lane[3].ok;
        for (int i = 0; i < NIBBLES; i++)
        begin
            s1_next.diff[i] = lane[i].diff;
        end
        s1_next.enc_code = '0;
        s1_next.rem      = d0.rem;
        s1_next.nib      = '0;
        s1_next.nib[0]   = d0.nib;
    end

    // ------------------------------------------------------------------
    // stage 2: lane merge, second decode step
    // ------------------------------------------------------------------
    snrc_dec_step #(.LEN(2)) u_step1 (
        .rem(s1_reg.rem), .prev(s1_reg.nib[0]), .res(d1));

    always_comb
    begin
        s2_next          = s1_reg;
        // unsorted input ranks as zero
        s2_next.enc_code = s1_reg.enc_ok ?
            (s1_reg.diff[0] + s1_reg.diff[1]) + (s1_reg.diff[2] + s1_reg.diff[3]) :
            '0;
        s2_next.rem      = d1.rem;
        s2_next.nib[1]   = d1.nib;
    end

    // ------------------------------------------------------------------
    // stage 3: third decode step
    // ------------------------------------------------------------------
    snrc_dec_step #(.LEN(1)) u_step2 (
        .rem(s2_reg.rem), .prev(s2_reg.nib[1]), .res(d2));

    always_comb
    begin
        s3_next        = s2_reg;
        s3_next.rem    = d2.rem;
        s3_next.nib[2] = d2.nib;
    end

    // ------------------------------------------------------------------
    // stage 4: last decode step, result formatting
    // ------------------------------------------------------------------
    snrc_dec_step #(.LEN(0)) u_step3 (
        .rem(s3_reg.rem), .prev(s3_reg.nib[2]), .res(d3));

    always_comb
    begin
        out_next = '0;
        if (s3_reg.op == OP_ENCODE)
        begin
            out_next.code_out = s3_reg.enc_code;
        end
        else if (!s3_reg.oor)
        begin
            out_next.out_nibble_0 = s3_reg.nib[0];
            out_next.out_nibble_1 = s3_reg.nib[1];
            out_next.out_nibble_2 = s3_reg.nib[2];
            out_next.out_nibble_3 = d3.nib;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free[0])
        begin
            s1_reg <= s1_next;
        end
        if (free[1])
        begin
            s2_reg <= s2_next;
        end
        if (free[2])
        begin
            s3_reg <= s3_next;
        end
        if (free[3])
        begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/snrc_enc_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snrc_enc_lane
// One encode lane: rank contribution of one nibble given its predecessor.
// ----------------------------------------------------------------------------
module snrc_enc_lane #(
    parameter int unsigned LEN = 3
) (
    input  snrc_pkg::nibble_t   nib,
    input  snrc_pkg::nibble_t   prev,
    output snrc_pkg::enc_lane_t res
);
    import snrc_pkg::*;

    code_t p_hi;
    code_t p_lo;

    assign p_hi     = PREFIX[LEN][{1'b0, nib}];
    assign p_lo     = PREFIX[LEN][{1'b0, prev}];
    assign res.diff = p_hi - p_lo;
    assign res.ok   = (nib >= prev);

endmodule
`default_nettype wire

/* rtl/core/snrc_dec_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snrc_dec_step
// One decode step: picks the next nibble with 15 threshold compare lanes.
// ----------------------------------------------------------------------------
module snrc_dec_step #(
    parameter int unsigned LEN = 3
) (
    input  snrc_pkg::code_t     rem,
    input  snrc_pkg::nibble_t   prev,
    output snrc_pkg::dec_step_t res
);
    import snrc_pkg::*;

    logic [CODE_W:0]    tgt;
    logic [VALUES-1:1]  le;
    nibble_t            v;

    // rebase the remaining rank onto the absolute prefix scale
    assign tgt = {1'b0, rem} + {1'b0, PREFIX[LEN][{1'b0, prev}]};

    always_comb
    begin
        for (int i = 1; i < VALUES; i++)
        begin
            le[i] = ({1'b0, PREFIX[LEN][i]} <= tgt);
        end
    end

    // prefix is strictly increasing, so le is a thermometer code
    assign v       = NIB_W'($countones(le));
    assign res.nib = v;
    assign res.rem = CODE_W'(tgt - {1'b0, PREFIX[LEN][{1'b0, v}]});

endmodule
`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted nibble rank codec. Encode and decode
// transactions go in through a queue-fed driver; a monitor compares every
// result against an in-bench rank/unrank predictor. Three traffic phases
// vary how often the sender idles and the receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

    import snrc_pkg::*;

    localparam int unsigned ITEMS_PER_PHASE = 600;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned MAX_CODE        = TOTAL_CODES - 1;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    in_item_t  pending_items [$];
    out_item_t expected_results [$];
    logic      in_fire       = 1'b0;
    int        errors        = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    sorted_nibble_rank_codec_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // number of non-decreasing tails of length len whose values are >= lo
    function automatic int unsigned tail_count(int unsigned len, int unsigned lo);
        int unsigned r;
        if (lo >= VALUES)
            return (len == 0) ? 1 : 0;
        r = VALUES - lo;
        case (len)
            0:       return 1;
            1:       return r;
            2:       return r * (r + 1) / 2;
            default: return r * (r + 1) * (r + 2) / 6;
        endcase
    endfunction

    function automatic out_item_t predict_codec(in_item_t it);
        out_item_t   res;
        int unsigned nib [4];
        int unsigned rank;
        int unsigned lo;
        int unsigned rem;
        int unsigned v;
        res = '0;
        lo  = 0;
        nib[0] = it.in_nibble_0;
        nib[1] = it.in_nibble_1;
        nib[2] = it.in_nibble_2;
        nib[3] = it.in_nibble_3;
        if (it.operation == OP_ENCODE)
        begin
            rank = 0;
            // unsorted tuples rank as zero
            if (nib[0] <= nib[1] && nib[1] <= nib[2] && nib[2] <= nib[3])
            begin
                for (int k = 0; k < NIBBLES; k++)
                begin
                    for (v = lo; v < nib[k]; v++)
                        rank += tail_count(NIBBLES - 1 - k, v);
                    lo = nib[k];
                end
            end
            res.code_out = code_t'(rank);
        end
        else
        begin
            rem = it.code_in;
            for (int k = 0; k < NIBBLES; k++)
                nib[k] = 0;
            if (rem < TOTAL_CODES)
            begin
                for (int k = 0; k < NIBBLES; k++)
                begin
                    v = lo;
                    while (v < VALUES - 1 && rem >= tail_count(NIBBLES - 1 - k, v))
                    begin
                        rem -= tail_count(NIBBLES - 1 - k, v);
                        v++;
                    end
                    nib[k] = v;
                    lo = v;
                end
            end
            res.out_nibble_0 = nibble_t'(nib[0]);
            res.out_nibble_1 = nibble_t'(nib[1]);
            res.out_nibble_2 = nibble_t'(nib[2]);
            res.out_nibble_3 = nibble_t'(nib[3]);
        end
        return res;
    endfunction

    // unused fields carry random junk; the block must ignore them
    function automatic in_item_t encode_item(int unsigned n0, int unsigned n1,
                                             int unsigned n2, int unsigned n3);
        in_item_t    it;
        int unsigned junk;
        junk           = $urandom;
        it             = junk[$bits(in_item_t)-1:0];
        it.operation   = OP_ENCODE;
        it.in_nibble_0 = nibble_t'(n0);
        it.in_nibble_1 = nibble_t'(n1);
        it.in_nibble_2 = nibble_t'(n2);
        it.in_nibble_3 = nibble_t'(n3);
        return it;
    endfunction

    function automatic in_item_t decode_item(int unsigned code);
        in_item_t    it;
        int unsigned junk;
        junk         = $urandom;
        it           = junk[$bits(in_item_t)-1:0];
        it.operation = OP_DECODE;
        it.code_in   = code_t'(code);
        return it;
    endfunction

    function automatic in_item_t random_item();
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        int unsigned vals [$];
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            // sorted tuple; a random window favors repeated values
            lo = $urandom_range(15);
            hi = $urandom_range(15, lo);
            for (int k = 0; k < NIBBLES; k++)
                vals.push_back($urandom_range(hi, lo));
            vals.sort();
            return encode_item(vals[0], vals[1], vals[2], vals[3]);
        end
        else if (pick < 65)
            return encode_item($urandom_range(15), $urandom_range(15),
                               $urandom_range(15), $urandom_range(15));
        else if (pick < 92)
            return decode_item($urandom_range(MAX_CODE));
        else
            return decode_item($urandom_range(4095, TOTAL_CODES));
    endfunction

    task automatic note_failure(string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // driver: new transaction or idle at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data  <= pending_items.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // accepted input transactions queue their predicted result
    always @(posedge clk)
    begin
        in_fire <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            expected_results.push_back(predict_codec(in_data));
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                note_failure($sformatf("unexpected result code=%0d nib=%0d,%0d,%0d,%0d",
                             out_data.code_out, out_data.out_nibble_0,
                             out_data.out_nibble_1, out_data.out_nibble_2,
                             out_data.out_nibble_3));
            else
            begin
                want = expected_results.pop_front();
                if (out_data.code_out     !== want.code_out     ||
                    out_data.out_nibble_0 !== want.out_nibble_0 ||
                    out_data.out_nibble_1 !== want.out_nibble_1 ||
                    out_data.out_nibble_2 !== want.out_nibble_2 ||
                    out_data.out_nibble_3 !== want.out_nibble_3)
                    note_failure($sformatf(
                        "exp code=%0d nib=%0d,%0d,%0d,%0d got code=%0d nib=%0d,%0d,%0d,%0d",
                        want.code_out, want.out_nibble_0, want.out_nibble_1,
                        want.out_nibble_2, want.out_nibble_3, out_data.code_out,
                        out_data.out_nibble_0, out_data.out_nibble_1,
                        out_data.out_nibble_2, out_data.out_nibble_3));
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct  = 10;
        recv_stall_pct = 88;

        // directed: range ends, ties, unsorted tuples, out-of-range codes
        pending_items.push_back(encode_item(0, 0, 0, 0));
        pending_items.push_back(encode_item(15, 15, 15, 15));
        pending_items.push_back(encode_item(0, 0, 0, 1));
        pending_items.push_back(encode_item(0, 0, 0, 15));
        pending_items.push_back(encode_item(0, 15, 15, 15));
        pending_items.push_back(encode_item(14, 15, 15, 15));
        pending_items.push_back(encode_item(0, 1, 2, 3));
        pending_items.push_back(encode_item(7, 7, 7, 7));
        pending_items.push_back(encode_item(3, 5, 9, 12));
        pending_items.push_back(encode_item(1, 0, 0, 0));
        pending_items.push_back(encode_item(15, 0, 0, 0));
        pending_items.push_back(encode_item(0, 0, 15, 14));
        pending_items.push_back(encode_item(15, 14, 13, 12));
        pending_items.push_back(encode_item(0, 5, 4, 9));
        pending_items.push_back(decode_item(0));
        pending_items.push_back(decode_item(1));
        pending_items.push_back(decode_item(15));
        pending_items.push_back(decode_item(16));
        pending_items.push_back(decode_item(MAX_CODE - 1));
        pending_items.push_back(decode_item(MAX_CODE));
        pending_items.push_back(decode_item(TOTAL_CODES));
        pending_items.push_back(decode_item(4095));
        pending_items.push_back(decode_item(2048));
        pending_items.push_back(decode_item(1937));
        wait_idle();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 88;
                end
                1:
                begin
                    send_idle_pct  = 88;
                    recv_stall_pct = 10;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                pending_items.push_back(random_item());
            // the next phase waits until the pipeline has fully drained
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_results.size()));

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
